// ===== design/rhsbm_pkg.sv =====
// Shared types and constants for the signal-strength bar meter.
// Used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package rhsbm_pkg;

	typedef enum logic [1:0] {
		CFG_FLOOR   = 2'd0,
		CFG_CEILING = 2'd1,
		CFG_CELLS   = 2'd2,
		CFG_RANGES  = 2'd3
	} cfg_idx_t;

	localparam logic [7:0] FLOOR_RST   = 8'd20;
	localparam logic [7:0] CEILING_RST = 8'd80;
	localparam logic [6:0] CELLS_RST   = 7'd37;
	localparam logic       RANGES_RST  = 1'b0;

	localparam logic [1:0] MISS_LOST = 2'd3;

	localparam logic [6:0] PCT_FULL  = 7'd100;
	localparam int         DIV_STEPS = 7;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x up to 91179
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int          RECIP_SHIFT = 23;

	localparam int         HDR_RANGES = 5;
	localparam logic [6:0] HDR_STEP [HDR_RANGES] = '{7'd17, 7'd34, 7'd50, 7'd67, 7'd84};
	localparam logic [2:0] HDR_PLAIN = 3'd6;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mul;
		logic recip;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic shown;
		logic need_div;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/rhsbm_if.sv =====
// Valid/ready channel interfaces for samples and meter results.
// Depends on nothing but the payload widths of the block.
`timescale 1ns / 1ps
`default_nettype none

interface rhsbm_in_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] raw_level;
	logic              frame_shown;

	modport source (output valid, output raw_level, output frame_shown, input ready);
	modport sink (input valid, input raw_level, input frame_shown, output ready);
endinterface

interface rhsbm_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] smoothed_level;
	logic        [6:0] percent;
	logic        [6:0] full_cells;
	logic        [2:0] partial_eighths;
	logic        [2:0] header_select;

	modport source (output valid, output smoothed_level, output percent, output full_cells,
		output partial_eighths, output header_select, input ready);
	modport sink (input valid, input smoothed_level, input percent, input full_cells,
		input partial_eighths, input header_select, output ready);
endinterface

`default_nettype wire

// ===== design/rhsbm_ctrl.sv =====
// Controller state machine: request handshakes and datapath sequencing.
// Depends on rhsbm_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rhsbm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire rhsbm_pkg::dp_status_t status,
	output rhsbm_pkg::dp_cmd_t         cmd
);

	localparam int CW = $clog2(rhsbm_pkg::DIV_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_RECIP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_vld_q;
	logic          out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (!status.shown) state_d = ST_IDLE;
				else if (status.need_div) state_d = ST_DIV;
				else state_d = ST_MUL;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(rhsbm_pkg::DIV_STEPS - 1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.recip = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PREP))
		else $error("accepted request did not advance to prep");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || out_ready))
		else $error("result loaded over an untaken result");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CW'(rhsbm_pkg::DIV_STEPS)))
		else $error("divider ran past its step count");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_DONE))
		else $error("result valid raised outside done");
`endif

endmodule

`default_nettype wire

// ===== design/rhsbm_dp.sv =====
// Datapath: config registers, hold-over, smoothing history, divider and bar scaling.
// Depends on rhsbm_pkg; sequenced by rhsbm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rhsbm_dp #(
	parameter int MAX_CELLS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [7:0]            cfg_data,
	input  wire logic signed [8:0]     raw_level,
	input  wire logic                  frame_shown,
	input  wire rhsbm_pkg::dp_cmd_t    cmd,
	output rhsbm_pkg::dp_status_t      status,
	output logic signed [8:0]          smoothed_level,
	output logic [6:0]                 percent,
	output logic [6:0]                 full_cells,
	output logic [2:0]                 partial_eighths,
	output logic [2:0]                 header_select
);

	logic [7:0] floor_q, ceil_q;
	logic [6:0] cells_cfg_q;
	logic       ranges_q;

	logic [7:0] last_good_q;
	logic [1:0] miss_run_q;
	logic [7:0] hist_q [2];
	logic [1:0] hist_vld_q;

	logic       shown_q, lost_q;
	logic [7:0] val_q;

	logic [14:0] rem_q, dsor_q;
	logic [6:0]  pct_q;
	logic [15:0] prod_q;
	logic [9:0]  total_q;

	logic signed [8:0] sm_q;
	logic [6:0]        pct_out_q, full_q;
	logic [2:0]        part_q, hdr_q;

	logic       present, hold_vld, use_avg;
	logic [1:0] miss_d;
	logic [7:0] hold_val, lvl;
	logic [9:0] sum;
	logic       gt_floor, ge_ceil;
	logic [7:0] diff, span;
	logic       ge;
	logic [6:0] cells, full;
	logic [2:0] part, hdr;

	assign present = frame_shown && !raw_level[8];
	assign miss_d  = (miss_run_q == rhsbm_pkg::MISS_LOST) ? miss_run_q : miss_run_q + 2'd1;

	always_comb begin
		if (present) begin
			hold_vld = 1'b1;
			hold_val = raw_level[7:0];
		end else begin
			hold_vld = (miss_d != rhsbm_pkg::MISS_LOST);
			hold_val = last_good_q;
		end
	end

	assign use_avg = hist_vld_q[0] && hist_vld_q[1];
	assign sum     = {1'b0, hold_val, 1'b0} + 10'(hist_q[0]) + 10'(hist_q[1]);
	assign lvl     = use_avg ? sum[9:2] : hold_val;

	assign gt_floor = !lost_q && (val_q > floor_q);
	assign ge_ceil  = (val_q >= ceil_q);
	assign diff     = val_q - floor_q;
	assign span     = ceil_q - floor_q;
	assign ge       = (rem_q >= dsor_q);

	assign status.shown    = shown_q;
	assign status.need_div = gt_floor && !ge_ceil;

	assign cells = (cells_cfg_q > 7'(MAX_CELLS)) ? 7'(MAX_CELLS) : cells_cfg_q;

	always_comb begin
		full = total_q[9:3];
		part = total_q[2:0];
		if (full > cells) begin
			full = cells;
			part = 3'd0;
		end
		hdr = 3'd0;
		for (int i = 0; i < rhsbm_pkg::HDR_RANGES; i++) begin
			if (pct_q >= rhsbm_pkg::HDR_STEP[i]) hdr = 3'(i + 1);
		end
		if (!ranges_q) hdr = rhsbm_pkg::HDR_PLAIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= rhsbm_pkg::FLOOR_RST;
			ceil_q      <= rhsbm_pkg::CEILING_RST;
			cells_cfg_q <= rhsbm_pkg::CELLS_RST;
			ranges_q    <= rhsbm_pkg::RANGES_RST;
			last_good_q <= 8'd0;
			miss_run_q  <= 2'd0;
			hist_vld_q  <= 2'b00;
			shown_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (rhsbm_pkg::cfg_idx_t'(cfg_index))
					rhsbm_pkg::CFG_FLOOR:   floor_q     <= cfg_data;
					rhsbm_pkg::CFG_CEILING: ceil_q      <= cfg_data;
					rhsbm_pkg::CFG_CELLS:   cells_cfg_q <= cfg_data[6:0];
					rhsbm_pkg::CFG_RANGES:  ranges_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				shown_q <= frame_shown;
				if (present) begin
					last_good_q <= raw_level[7:0];
					miss_run_q  <= 2'd0;
				end else begin
					miss_run_q <= miss_d;
				end
				if (hold_vld) hist_vld_q <= {hist_vld_q[0], 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lost_q <= !hold_vld;
			val_q  <= lvl;
			if (hold_vld) begin
				hist_q[0] <= hold_val;
				hist_q[1] <= hist_q[0];
			end
		end
		if (cmd.prep) begin
			pct_q  <= (gt_floor && ge_ceil) ? rhsbm_pkg::PCT_FULL : 7'd0;
			rem_q  <= 15'(diff) * 15'(rhsbm_pkg::PCT_FULL);
			dsor_q <= 15'(span) << (rhsbm_pkg::DIV_STEPS - 1);
		end
		if (cmd.div_step) begin
			if (ge) rem_q <= rem_q - dsor_q;
			dsor_q <= dsor_q >> 1;
			pct_q  <= {pct_q[5:0], ge};
		end
		if (cmd.mul) prod_q <= 16'({14'(pct_q) * 14'(cells), 3'b000});
		if (cmd.recip) total_q <= 10'((33'(prod_q) * 33'(rhsbm_pkg::RECIP_100))
			>> rhsbm_pkg::RECIP_SHIFT);
		if (cmd.out_load) begin
			sm_q      <= lost_q ? -9'sd1 : $signed({1'b0, val_q});
			pct_out_q <= pct_q;
			full_q    <= full;
			part_q    <= part;
			hdr_q     <= hdr;
		end
	end

	assign smoothed_level  = sm_q;
	assign percent         = pct_out_q;
	assign full_cells      = full_q;
	assign partial_eighths = part_q;
	assign header_select   = hdr_q;

endmodule

`default_nettype wire

// ===== design/rssi_hold_smooth_bar_meter.sv =====
// Top level of the signal-strength bar meter: channels, config port, controller, datapath.
// Depends on rhsbm_pkg, rhsbm_if, rhsbm_ctrl and rhsbm_dp.
//
//   channel   dir  flow        payload
//   samples   in   valid/ready raw_level, frame_shown
//   results   out  valid/ready smoothed_level, percent, full_cells, partial_eighths,
//                              header_select
//   cfg       in   write only  cfg_we, cfg_index, cfg_data
//
// A shown frame goes through prep, multiply, reciprocal and done after accept, raising
// result valid after done; the next request is taken back in idle. The 7-step restoring
// divider (one quotient bit per cycle) runs after prep if the level is not lost and lies
// strictly between floor and ceiling. An unshown frame returns to idle with no result.
// An untaken result holds the controller in its done state and stalls the next request.
// Reset restores config defaults and clears hold-over, history valid and handshake state.
`timescale 1ns / 1ps
`default_nettype none

module rssi_hold_smooth_bar_meter #(
	parameter int MAX_CELLS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rhsbm_in_if.sink        samples,
	rhsbm_out_if.source     results,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	rhsbm_pkg::dp_cmd_t    cmd;
	rhsbm_pkg::dp_status_t status;

	rhsbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rhsbm_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.raw_level       (samples.raw_level),
		.frame_shown     (samples.frame_shown),
		.cmd             (cmd),
		.status          (status),
		.smoothed_level  (results.smoothed_level),
		.percent         (results.percent),
		.full_cells      (results.full_cells),
		.partial_eighths (results.partial_eighths),
		.header_select   (results.header_select)
	);

endmodule

`default_nettype wire
